FILE: hdl/hxis_pkg.sv
package hxis_pkg;

  // lattice geometry
  localparam int SIDE    = 32;
  localparam int COORD_W = $clog2(SIDE);
  localparam int ROWS    = 2 * SIDE;            // one memory row per (sublattice, row)
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int NSITES  = 2 * SIDE * SIDE;

  // field widths
  localparam int FIELD_COORD_W = 5;
  localparam int REQ_W         = 2;
  localparam int RND_W         = 32;
  localparam int DE_W          = 4;
  localparam int SUM_W         = 13;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int S_TDATA_W     = 48;
  localparam int S_TUSER_W     = 2;
  localparam int M_TDATA_W     = 32;

  // request codes; the unused code behaves as a read
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_RISE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_RISE = 1'd1;

  localparam logic [CFG_W-1:0] SMALL_RISE_RESET = 32'd12973000;
  localparam logic [CFG_W-1:0] LARGE_RISE_RESET = 32'd118;
  localparam logic [SUM_W-1:0] MAG_RESET  = SUM_W'(NSITES);
  localparam logic [SUM_W-1:0] BOND_RESET = SUM_W'(3 * SIDE * SIDE);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ROW_AW-1:0]  row_addr_t;
  typedef logic [SIDE-1:0]    spin_row_t;

  typedef struct packed {
    logic      capture;    // input word accepted this cycle
    logic      load_rows;  // own and partner rows on the read ports
    logic      commit;     // adjacent row on port b, result register free
    logic      clear_we;
    row_addr_t clear_addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ctrl_stat_t;

  function automatic row_addr_t row_addr(input logic sub, input coord_t r);
    return ROW_AW'(int'(sub) * SIDE + int'(r));
  endfunction

  function automatic coord_t coord_dec(input coord_t v);
    return (v == '0) ? COORD_W'(SIDE - 1) : v - 1'b1;
  endfunction

  function automatic coord_t coord_inc(input coord_t v);
    return (v == COORD_W'(SIDE - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic coord_t coord_wrap(input logic [FIELD_COORD_W-1:0] v);
    return COORD_W'(v % SIDE);
  endfunction

endpackage

FILE: hdl/hxis_ram.sv
module hxis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hdl/hxis_ctrl.sv
module hxis_ctrl
  import hxis_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output ctrl_cmd_t  cmd,
  input  ctrl_stat_t stat
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  state_t    state;
  row_addr_t clear_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_cnt <= '0;
      s_tready  <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clear_cnt <= clear_cnt + 1'b1;
          if (clear_cnt == ROW_AW'(ROWS - 1)) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state    <= ST_READ;
            s_tready <= 1'b0;
          end
        end
        ST_READ: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (!stat.out_busy) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  assign cmd.capture    = s_tvalid && s_tready;
  assign cmd.load_rows  = (state == ST_READ);
  assign cmd.commit     = (state == ST_EXEC) && !stat.out_busy;
  assign cmd.clear_we   = (state == ST_CLEAR);
  assign cmd.clear_addr = clear_cnt;

endmodule

FILE: hdl/hxis_datapath.sv
module hxis_datapath
  import hxis_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  ctrl_cmd_t            cmd,
  output ctrl_stat_t           stat
);

  // captured request
  logic [REQ_W-1:0] req;
  coord_t           c;
  coord_t           r;
  logic             sub;
  logic             val;
  logic [RND_W-1:0] rnd;
  spin_row_t        own_row;
  spin_row_t        oth_row;

  logic [CFG_W-1:0] small_rise;
  logic [CFG_W-1:0] large_rise;
  logic [SUM_W-1:0] mag_total;
  logic [SUM_W-1:0] bond_total;

  logic             out_flipped;
  logic             out_spin;
  logic [DE_W-1:0]  out_de;

  // incoming fields
  coord_t    in_c;
  coord_t    in_r;
  logic      in_sub;

  row_addr_t raddr_a;
  row_addr_t raddr_b;
  spin_row_t rdata_a;
  spin_row_t rdata_b;
  logic      ram_we;
  row_addr_t ram_waddr;
  spin_row_t ram_wdata;

  coord_t    c_side;
  coord_t    r_adj;
  logic [1:0] up_cnt;
  logic       own;
  logic signed [DE_W-1:0] de_raw;
  logic       take;
  logic       change;
  logic       spin_new;
  spin_row_t  new_row;

  assign in_c   = coord_wrap(s_tdata[4:0]);
  assign in_r   = coord_wrap(s_tdata[9:5]);
  assign in_sub = s_tdata[10];

  // sublattice 0 bonds to (c-1,r),(c,r),(c,r-1); sublattice 1 to (c+1,r),(c,r),(c,r+1)
  assign c_side = sub ? coord_inc(c) : coord_dec(c);
  assign r_adj  = sub ? coord_inc(r) : coord_dec(r);

  // accept cycle reads own and partner rows, later cycles hold port b on the adjacent row
  assign raddr_a = row_addr(in_sub, in_r);
  assign raddr_b = cmd.capture ? row_addr(!in_sub, in_r) : row_addr(!sub, r_adj);

  hxis_ram #(
    .WIDTH(SIDE),
    .DEPTH(ROWS)
  ) u_spin_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .raddr_b(raddr_b),
    .rdata_b(rdata_b)
  );

  always_comb begin
    up_cnt = 2'(oth_row[c]) + 2'(oth_row[c_side]) + 2'(rdata_b[c]);
    own    = own_row[c];
    // de = 2*s*(2k-3)
    de_raw = own ? DE_W'(4 * int'(up_cnt) - 6) : DE_W'(6 - 4 * int'(up_cnt));
    if (de_raw[DE_W-1]) begin
      take = 1'b1;
    end else if (de_raw == DE_W'(2)) begin
      take = rnd < small_rise;
    end else begin
      take = rnd < large_rise;
    end
    priority if (req == REQ_LOAD) begin
      change = (own != val);
    end else if (req == REQ_UPDATE) begin
      change = take;
    end else begin
      change = 1'b0;
    end
    spin_new    = own ^ change;
    new_row     = own_row;
    new_row[c]  = spin_new;
  end

  always_comb begin
    if (cmd.clear_we) begin
      ram_we    = 1'b1;
      ram_waddr = cmd.clear_addr;
      ram_wdata = '1;
    end else begin
      ram_we    = cmd.commit && change;
      ram_waddr = row_addr(sub, r);
      ram_wdata = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= s_tuser;
      c   <= in_c;
      r   <= in_r;
      sub <= in_sub;
      val <= s_tdata[11];
      rnd <= s_tdata[43:12];
    end
    if (cmd.load_rows) begin
      own_row <= rdata_a;
      oth_row <= rdata_b;
    end
    if (cmd.commit) begin
      out_flipped <= (req == REQ_UPDATE) && change;
      out_spin    <= spin_new;
      out_de      <= (req == REQ_UPDATE) ? de_raw : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      small_rise <= SMALL_RISE_RESET;
      large_rise <= LARGE_RISE_RESET;
      mag_total  <= MAG_RESET;
      bond_total <= BOND_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SMALL_RISE: small_rise <= cfg_data;
          REG_LARGE_RISE: large_rise <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit && change) begin
        // flipping spin s moves magnetization by -2s and bonds by -de
        mag_total  <= own ? mag_total - SUM_W'(2) : mag_total + SUM_W'(2);
        bond_total <= bond_total - SUM_W'(de_raw);
      end
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign stat.out_busy = m_tvalid && !m_tready;
  assign m_tdata = {bond_total, mag_total, out_de, out_spin, out_flipped};

endmodule

FILE: hdl/hex_ising_metropolis_update_unit.sv
// channel   dir  signals                            word
// s_*       in   s_tvalid s_tready s_tdata s_tuser  one request
// m_*       out  m_tvalid m_tready m_tdata          one result per request
// cfg_*     in   cfg_we cfg_index cfg_data          threshold register write
//
// Each request goes through these steps in order: accept with own and partner spin rows read on
// the two RAM ports, adjacent row read, then decide and write back. The
// adjacent row gets a read of its own because the spin row RAM has only two
// read ports. After reset a clearing pass sets every spin to +1; s_tready
// stays low until the pass has written all 64 RAM rows. A stalled result holds
// the block in its last step until m_tready; the next request is taken once
// the result is registered.
module hex_ising_metropolis_update_unit
  import hxis_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // col[4:0], row[9:5], sublattice[10], spin_value[11], random_word[43:12], zero fill
  input  logic [S_TDATA_W-1:0] s_tdata,
  // req_type[1:0]
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // flipped[0], spin_now[1], energy_change[5:2], magnetization[18:6], bond_sum[31:19]
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  hxis_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .cmd     (cmd),
    .stat    (stat)
  );

  hxis_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

FILE: dv/hex_ising_metropolis_update_unit_tb.sv
module hex_ising_metropolis_update_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hxis_pkg::*;

  // unused request code, behaves as a read
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic                    flipped;
    logic                    spin_now;
    logic signed [DE_W-1:0]  energy_change;
    logic signed [SUM_W-1:0] magnetization;
    logic signed [SUM_W-1:0] bond_sum;
  } spin_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [S_TUSER_W-1:0] s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // lattice model
  bit           lattice_spin [NSITES];
  int           mag_sum;
  int           bond_total_sum;
  logic [CFG_W-1:0] small_rise_thr;
  logic [CFG_W-1:0] large_rise_thr;
  spin_result_t pending_results [$];

  int err_count  = 0;
  int n_loads    = 0;
  int n_updates  = 0;
  int n_flips    = 0;
  int n_reads    = 0;
  int n_results  = 0;
  int n_settings = 1;

  bit src_gaps_on    = 1'b1;
  bit sink_stalls_on = 1'b1;
  bit hold_request   = 1'b0;

  hex_ising_metropolis_update_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int site_of(input bit sub, input int c, input int r);
    return (int'(sub) * SIDE + r) * SIDE + c;
  endfunction

  function automatic int spin_pm(input int idx);
    return lattice_spin[idx] ? 1 : -1;
  endfunction

  // all three neighbours sit on the other sublattice
  function automatic int neighbour_spin_sum(input bit sub, input int c, input int r);
    int cm, cp, rm, rp;
    cm = (c + SIDE - 1) % SIDE;
    cp = (c + 1) % SIDE;
    rm = (r + SIDE - 1) % SIDE;
    rp = (r + 1) % SIDE;
    if (!sub)
      return spin_pm(site_of(1'b1, cm, r)) + spin_pm(site_of(1'b1, c, r)) +
             spin_pm(site_of(1'b1, c, rm));
    return spin_pm(site_of(1'b0, cp, r)) + spin_pm(site_of(1'b0, c, r)) +
           spin_pm(site_of(1'b0, c, rp));
  endfunction

  function automatic void flip_site(input int idx, input int nsum);
    int old;
    old = spin_pm(idx);
    lattice_spin[idx] = ~lattice_spin[idx];
    mag_sum        -= 2 * old;
    bond_total_sum -= 2 * old * nsum;
  endfunction

  function automatic spin_result_t predict_request(
    input logic [REQ_W-1:0] req, input logic [FIELD_COORD_W-1:0] col,
    input logic [FIELD_COORD_W-1:0] row, input logic sub, input logic val,
    input logic [RND_W-1:0] rnd);
    int c, r, idx, nsum, de;
    bit take;
    spin_result_t res;
    c    = int'(col) % SIDE;
    r    = int'(row) % SIDE;
    idx  = site_of(sub, c, r);
    nsum = neighbour_spin_sum(sub, c, r);
    de   = 0;
    res.flipped = 1'b0;
    if (req == REQ_LOAD) begin
      if (lattice_spin[idx] != val) flip_site(idx, nsum);
    end else if (req == REQ_UPDATE) begin
      de = 2 * spin_pm(idx) * nsum;
      if (de < 0)       take = 1'b1;
      else if (de == 2) take = rnd < small_rise_thr;
      else              take = rnd < large_rise_thr;
      if (take) begin
        flip_site(idx, nsum);
        res.flipped = 1'b1;
      end
    end
    res.spin_now      = lattice_spin[idx];
    res.energy_change = DE_W'(de);
    res.magnetization = SUM_W'(mag_sum);
    res.bond_sum      = SUM_W'(bond_total_sum);
    return res;
  endfunction

  function automatic logic [RND_W-1:0] pick_random_word();
    case ($urandom_range(0, 5))
      0:       return small_rise_thr - RND_W'($urandom_range(0, 1));
      1:       return large_rise_thr - RND_W'($urandom_range(0, 1));
      2:       return RND_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_result(input logic [M_TDATA_W-1:0] word);
    spin_result_t got, want;
    got.flipped       = word[0];
    got.spin_now      = word[1];
    got.energy_change = word[5:2];
    got.magnetization = word[18:6];
    got.bond_sum      = word[31:19];
    n_results++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result word %h", word));
    end else begin
      want = pending_results.pop_front();
      if (got.flipped !== want.flipped)
        report_mismatch($sformatf("flipped %b, want %b", got.flipped, want.flipped));
      if (got.spin_now !== want.spin_now)
        report_mismatch($sformatf("spin_now %b, want %b", got.spin_now, want.spin_now));
      if (got.energy_change !== want.energy_change)
        report_mismatch($sformatf("energy_change %0d, want %0d",
                                  got.energy_change, want.energy_change));
      if (got.magnetization !== want.magnetization)
        report_mismatch($sformatf("magnetization %0d, want %0d",
                                  got.magnetization, want.magnetization));
      if (got.bond_sum !== want.bond_sum)
        report_mismatch($sformatf("bond_sum %0d, want %0d", got.bond_sum, want.bond_sum));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
  end

  // output side: random stalls, plus one long hold on request
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        for (int k = 0; k < LONG_HOLD_CYCLES; k++) @(posedge clk);
        m_tready <= 1'b1;
      end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic [FIELD_COORD_W-1:0] col,
                              input logic [FIELD_COORD_W-1:0] row,
                              input logic sub, input logic val,
                              input logic [RND_W-1:0] rnd);
    spin_result_t want;
    int gap;
    s_tuser  <= req;
    s_tdata  <= S_TDATA_W'({rnd, val, sub, row, col});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    want = predict_request(req, col, row, sub, val, rnd);
    pending_results.push_back(want);
    case (req)
      REQ_LOAD:   n_loads++;
      REQ_UPDATE: n_updates++;
      default:    n_reads++;
    endcase
    if (want.flipped) n_flips++;
    if (src_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SMALL_RISE) small_rise_thr = value;
    else                       large_rise_thr = value;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [CFG_W-1:0] small_thr,
                                input logic [CFG_W-1:0] large_thr);
    drain_results();
    write_threshold(REG_SMALL_RISE, small_thr);
    write_threshold(REG_LARGE_RISE, large_thr);
    n_settings++;
  endtask

  // half of the requests land in a small moving window so spins interact
  task automatic send_random_requests(input int count);
    logic [REQ_W-1:0] req;
    logic [FIELD_COORD_W-1:0] col, row, base_c, base_r;
    int pick;
    base_c = FIELD_COORD_W'($urandom);
    base_r = FIELD_COORD_W'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 63) == 0) begin
        base_c = FIELD_COORD_W'($urandom);
        base_r = FIELD_COORD_W'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 25)      req = REQ_LOAD;
      else if (pick < 80) req = REQ_UPDATE;
      else if (pick < 93) req = REQ_READ;
      else                req = REQ_SPARE;
      if ($urandom_range(0, 1)) begin
        col = base_c + FIELD_COORD_W'($urandom_range(0, 3));
        row = base_r + FIELD_COORD_W'($urandom_range(0, 3));
      end else begin
        col = FIELD_COORD_W'($urandom);
        row = FIELD_COORD_W'($urandom);
      end
      send_request(req, col, row, 1'($urandom), 1'($urandom), pick_random_word());
    end
  endtask

  task automatic test_directed_cases();
    send_request(REQ_READ,   5'd0,  5'd0,  1'b0, 1'b0, 32'd0);
    send_request(REQ_SPARE,  5'd31, 5'd31, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_request(REQ_LOAD,   5'd31, 5'd31, 1'b1, 1'b1, 32'd0);   // same value, no change
    // 6J rise: rejected above and at the threshold, taken just below
    send_request(REQ_UPDATE, 5'd0,  5'd0,  1'b0, 1'b0, 32'hFFFF_FFFF);
    send_request(REQ_UPDATE, 5'd0,  5'd0,  1'b0, 1'b0, LARGE_RISE_RESET);
    send_request(REQ_UPDATE, 5'd0,  5'd0,  1'b0, 1'b0, LARGE_RISE_RESET - 1'b1);
    send_request(REQ_UPDATE, 5'd0,  5'd0,  1'b0, 1'b0, 32'hFFFF_FFFF);  // downhill
    // neighbour set to -1 by a load gives a 2J rise
    send_request(REQ_LOAD,   5'd0,  5'd0,  1'b1, 1'b0, 32'd0);
    send_request(REQ_UPDATE, 5'd0,  5'd0,  1'b0, 1'b1, SMALL_RISE_RESET);
    send_request(REQ_UPDATE, 5'd0,  5'd0,  1'b0, 1'b1, SMALL_RISE_RESET - 1'b1);
    send_request(REQ_UPDATE, 5'd0,  5'd0,  1'b0, 1'b0, 32'hFFFF_FFFF);
    send_request(REQ_LOAD,   5'd0,  5'd0,  1'b1, 1'b1, 32'hFFFF_FFFF);
    // wrap across the lattice corner
    send_request(REQ_UPDATE, 5'd31, 5'd31, 1'b1, 1'b0, 32'd0);
    send_request(REQ_READ,   5'd31, 5'd31, 1'b1, 1'b0, 32'd0);
    send_request(REQ_UPDATE, 5'd0,  5'd31, 1'b0, 1'b1, 32'd0);
    send_request(REQ_UPDATE, 5'd31, 5'd0,  1'b0, 1'b1, 32'd0);
    send_request(REQ_LOAD,   5'd31, 5'd31, 1'b1, 1'b1, 32'd0);
    send_request(REQ_LOAD,   5'd31, 5'd0,  1'b0, 1'b0, 32'hFFFF_FFFF);
    send_request(REQ_READ,   5'd31, 5'd0,  1'b0, 1'b1, 32'hFFFF_FFFF);
    send_request(REQ_SPARE,  5'd31, 5'd0,  1'b0, 1'b1, 32'd0);
  endtask

  task automatic test_reset_thresholds();
    send_random_requests(330);
  endtask

  task automatic test_always_accept();
    set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random_requests(300);
  endtask

  task automatic test_never_accept();
    set_thresholds(32'd0, 32'd0);
    send_random_requests(280);
  endtask

  task automatic test_random_thresholds();
    set_thresholds($urandom, $urandom);
    send_random_requests(145);
    set_thresholds(32'hFFFF_FFFF, 32'd0);
    send_random_requests(145);
  endtask

  // output held off while input keeps coming; the block must stall its input
  task automatic test_output_backpressure();
    src_gaps_on  = 1'b0;
    hold_request = 1'b1;
    send_random_requests(30);
    src_gaps_on  = 1'b1;
  endtask

  task automatic test_streaming_no_idle();
    set_thresholds(SMALL_RISE_RESET, LARGE_RISE_RESET);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    send_random_requests(200);
  endtask

  initial begin : run_tests
    for (int i = 0; i < NSITES; i++) lattice_spin[i] = 1'b1;
    mag_sum        = NSITES;
    bond_total_sum = 3 * SIDE * SIDE;
    small_rise_thr = SMALL_RISE_RESET;
    large_rise_thr = LARGE_RISE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_reset_thresholds();
    test_always_accept();
    test_never_accept();
    test_random_thresholds();
    test_output_backpressure();
    test_streaming_no_idle();
    drain_results();
    $display("ran %0d loads, %0d updates (%0d flipped) and %0d reads, %0d results checked",
             n_loads, n_updates, n_flips, n_reads, n_results);
    $display("%0d threshold settings, random stalls both sides, one %0d-cycle output hold",
             n_settings, LONG_HOLD_CYCLES);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("timeout, %0d words still expected", pending_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
